// ===== hdl/wvs_pkg.sv =====
package wvs_pkg;

  localparam int ELEMS         = 12;
  localparam int WEIGHT_BITS   = 16;
  localparam int JOINTS_DEF    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RUN_CYCLES    = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TERM  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         joint;
    logic [3:0]         element;
    logic signed [31:0] value;
    logic [16:0]        weight;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  typedef struct packed {
    logic       cap;
    logic       wr;
    logic       rd;
    logic [3:0] rd_elem;
    logic       emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// ===== hdl/wvs_in_if.sv =====
interface wvs_in_if;
  import wvs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/wvs_out_if.sv =====
interface wvs_out_if;
  import wvs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ===== hdl/wvs_ctrl.sv =====
module wvs_ctrl #(
  parameter int JOINTS = wvs_pkg::JOINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  wvs_in_if.sink              feed,
  input  wvs_pkg::dp_status_t st,
  output wvs_pkg::ctl_cmd_t   cmd
);
  import wvs_pkg::*;

  typedef enum logic [2:0] {
    IDLE = 3'b001,
    RUN  = 3'b010,
    EMIT = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [4:0] cnt;
  logic       last_q;
  logic       accept;
  logic       joint_ok;

  assign feed.ready = (state == IDLE);
  assign accept     = feed.valid && feed.ready;
  assign joint_ok   = (32'(feed.item.joint) < JOINTS);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (accept) begin
          if (feed.item.cmd == CMD_WRITE) begin
            cmd.wr = joint_ok && (32'(feed.item.element) < ELEMS);
          end else begin
            cmd.cap = 1'b1;
            if (joint_ok) begin
              state_next = RUN;
            end else if (feed.item.last_term) begin
              state_next = EMIT;
            end
          end
        end
      end
      RUN: begin
        cmd.rd      = (32'(cnt) < ELEMS);
        cmd.rd_elem = cnt[3:0];
        if (32'(cnt) == RUN_CYCLES - 1) begin
          state_next = last_q ? EMIT : IDLE;
        end
      end
      EMIT: begin
        if (!st.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      cnt    <= '0;
      last_q <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.cap) begin
        last_q <= feed.item.last_term;
      end
      if (state == RUN && state_next == RUN) begin
        cnt <= cnt + 5'd1;
      end else begin
        cnt <= '0;
      end
    end
  end

  a_emit_needs_last: assert property (@(posedge clk) disable iff (rst)
    state == EMIT |-> last_q)
    else $error("emit without last term");
  a_run_entry: assert property (@(posedge clk) disable iff (rst)
    (state == RUN && cnt == 5'd0) |-> $past(state) == IDLE)
    else $error("run started outside idle");

endmodule

// ===== hdl/wvs_dp.sv =====
module wvs_dp #(
  parameter int JOINTS    = wvs_pkg::JOINTS_DEF,
  parameter int FRAC_BITS = wvs_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wvs_pkg::in_item_t   item,
  input  wvs_pkg::ctl_cmd_t   cmd,
  output wvs_pkg::dp_status_t st,
  wvs_out_if.source           result
);
  import wvs_pkg::*;

  localparam int DEPTH  = JOINTS * ELEMS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [31:0] mem [DEPTH];

  logic [4:0]         joint_q;
  logic [16:0]        weight_q;
  logic signed [31:0] px, py, pz;

  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [9:0]         wr_sum, rd_sum;

  logic               v1, v2, v3, v4;
  logic [3:0]         e1, e2;
  logic [1:0]         row3, row4;
  logic signed [31:0] rd_data, trans, comp, pos_sel;
  logic signed [63:0] prod;
  logic signed [65:0] rowsum;
  logic signed [49:0] wprod;
  logic signed [63:0] acc [3];
  logic signed [64:0] acc_sum;
  logic               out_valid;
  out_item_t          out_item;

  assign wr_sum  = 10'({item.joint, 3'b000}) + 10'({item.joint, 2'b00}) + 10'(item.element);
  assign rd_sum  = 10'({joint_q, 3'b000}) + 10'({joint_q, 2'b00}) + 10'(cmd.rd_elem);
  assign wr_addr = ADDR_W'(wr_sum);
  assign rd_addr = ADDR_W'(rd_sum);

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= item.value;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      joint_q  <= item.joint;
      weight_q <= item.weight;
      px       <= item.pos_x;
      py       <= item.pos_y;
      pz       <= item.pos_z;
    end
  end

  always_comb begin
    case (e1[1:0])
      2'd0:    pos_sel = px;
      2'd1:    pos_sel = py;
      default: pos_sel = pz;
    endcase
  end

  assign acc_sum = 65'(acc[row4]) + 65'(wprod);

  always_ff @(posedge clk) begin
    e1    <= cmd.rd_elem;
    e2    <= e1;
    prod  <= rd_data * pos_sel;
    trans <= rd_data;
    if (v2 && e2[1:0] != 2'd3) begin
      rowsum <= ((e2[1:0] == 2'd0) ? 66'sd0 : rowsum) + 66'(prod);
    end
    if (v2 && e2[1:0] == 2'd3) begin
      comp <= sat32((rowsum >>> FRAC_BITS) + 66'(trans));
      row3 <= e2[3:2];
    end
    wprod <= comp * $signed({1'b0, weight_q});
    row4  <= row3;
    if (cmd.emit) begin
      out_item.out_x <= sat32(66'(acc[0] >>> WEIGHT_BITS));
      out_item.out_y <= sat32(66'(acc[1] >>> WEIGHT_BITS));
      out_item.out_z <= sat32(66'(acc[2] >>> WEIGHT_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      acc[0]    <= '0;
      acc[1]    <= '0;
      acc[2]    <= '0;
      out_valid <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
      v3 <= v2 && e2[1:0] == 2'd3;
      v4 <= v3;
      if (cmd.emit) begin
        acc[0]    <= '0;
        acc[1]    <= '0;
        acc[2]    <= '0;
        out_valid <= 1'b1;
      end else begin
        if (v4) begin
          if (acc_sum[64] != acc_sum[63]) begin
            acc[row4] <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            acc[row4] <= acc_sum[63:0];
          end
        end
        if (result.ready) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign result.valid = out_valid;
  assign result.item  = out_item;
  assign st.out_busy  = out_valid && !result.ready;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(result.ready))
    else $error("item dropped before taken");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !v4 && !(out_valid && !result.ready))
    else $error("emit collides with pending work");

endmodule

// ===== hdl/weighted_vertex_skinning.sv =====
// Linear blend skinning in signed fixed point. A write item (cmd 0) stores one
// of the twelve elements (three rows of four) of a joint transform. A term
// item (cmd 1) reads the twelve elements one per cycle from the transform
// memory and passes them through a shared 32x32 multiplier, row adder,
// weight multiplier and accumulator pipeline; a last term then loads the
// output register and clears the sums once the previous result is taken.
// A term with an out-of-range joint adds nothing, but a last one still emits.
module weighted_vertex_skinning #(
  parameter int JOINTS    = wvs_pkg::JOINTS_DEF,
  parameter int FRAC_BITS = wvs_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  wvs_in_if.sink     feed,
  wvs_out_if.source  result
);
  import wvs_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;

  wvs_ctrl #(.JOINTS(JOINTS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .feed (feed),
    .st   (st),
    .cmd  (cmd)
  );

  wvs_dp #(.JOINTS(JOINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (feed.item),
    .cmd    (cmd),
    .st     (st),
    .result (result)
  );

endmodule
